/* rtl/mfr_pkg.sv */
package mfr_pkg;

	localparam int FRAME_LENGTH = 18;
	localparam int LAST_POS = FRAME_LENGTH - 1;
	localparam int BODY_POS = 2;
	localparam int WORD_COUNT = FRAME_LENGTH / 2;
	localparam int POS_W = 5;
	localparam int BUSY_BIT = 8;
	localparam logic [15:0] MARKER_RESET = 16'hABCD;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = 1;
	localparam int QUEUE_CW = 2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       mission_active;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] word_cmd1;
		logic signed [15:0] word_cmd2;
		logic signed [15:0] speed_right;
		logic signed [15:0] speed_left;
		logic signed [15:0] battery_voltage;
		logic signed [15:0] board_temperature;
		logic        [15:0] led_word;
		logic               busy_res;
		logic signed [15:0] distance_left;
		logic signed [15:0] distance_right;
	} out_item_t;

	// Checked frame on its way from the deframer to the result stage.
	typedef struct packed {
		logic signed [15:0] cmd1;
		logic signed [15:0] cmd2;
		logic signed [15:0] speed_right;
		logic signed [15:0] speed_left;
		logic signed [15:0] battery_voltage;
		logic signed [15:0] board_temperature;
		logic        [15:0] led_word;
		logic               mission_active;
	} frame_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_sts_t;

endpackage

/* rtl/mfr_front.sv */
module mfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data,
	input  logic              accept,
	input  mfr_pkg::in_item_t item,
	output logic              push,
	output mfr_pkg::frame_t   frame
);

	logic [15:0]                   marker_q;
	logic [7:0]                    prev_q;
	logic [mfr_pkg::POS_W-1:0]     pos_q;
	logic [7:0]                    bytes_q [mfr_pkg::FRAME_LENGTH];

	logic [15:0]                   pattern;
	logic                          hit;
	logic                          in_frame;
	logic                          last;
	logic [15:0]                   words [mfr_pkg::WORD_COUNT];
	logic [15:0]                   xsum;

	assign pattern  = {item.rx_byte, prev_q};
	assign hit      = (pattern == marker_q);
	assign in_frame = (pos_q >= mfr_pkg::POS_W'(mfr_pkg::BODY_POS)) &&
	                  (pos_q < mfr_pkg::POS_W'(mfr_pkg::FRAME_LENGTH));
	assign last     = !hit && (pos_q == mfr_pkg::POS_W'(mfr_pkg::LAST_POS));

	// Final word takes the incoming byte as its high half.
	always_comb begin
		for (int k = 0; k < mfr_pkg::WORD_COUNT - 1; k++) begin
			words[k] = {bytes_q[2*k+1], bytes_q[2*k]};
		end
		words[mfr_pkg::WORD_COUNT-1] = {item.rx_byte, bytes_q[mfr_pkg::LAST_POS-1]};
		xsum = '0;
		for (int k = 0; k < mfr_pkg::WORD_COUNT - 1; k++) begin
			xsum = xsum ^ words[k];
		end
	end

	assign push = accept && last && (xsum == words[mfr_pkg::WORD_COUNT-1]);

	always_comb begin
		frame.cmd1              = words[1];
		frame.cmd2              = words[2];
		frame.speed_right       = words[3];
		frame.speed_left        = words[4];
		frame.battery_voltage   = words[5];
		frame.board_temperature = words[6];
		frame.led_word          = words[7];
		frame.mission_active    = item.mission_active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= mfr_pkg::MARKER_RESET;
			prev_q   <= '0;
			pos_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				marker_q <= cfg_wr_data;
			end
			if (accept) begin
				prev_q <= item.rx_byte;
				if (hit) begin
					pos_q <= mfr_pkg::POS_W'(mfr_pkg::BODY_POS);
				end else if (last) begin
					pos_q <= '0;
				end else if (in_frame) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Frame store: start pair on a marker hit, otherwise one byte at the position.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (hit) begin
				bytes_q[0] <= prev_q;
				bytes_q[1] <= item.rx_byte;
			end else if (in_frame) begin
				for (int i = mfr_pkg::BODY_POS; i < mfr_pkg::FRAME_LENGTH; i++) begin
					if (pos_q == mfr_pkg::POS_W'(i)) begin
						bytes_q[i] <= item.rx_byte;
					end
				end
			end
		end
	end

endmodule

/* rtl/mfr_queue.sv */
module mfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfr_pkg::queue_ctl_t   ctl,
	input  mfr_pkg::frame_t       wr_data,
	output mfr_pkg::queue_sts_t   sts,
	output mfr_pkg::frame_t       rd_data
);

	mfr_pkg::frame_t                mem_q [mfr_pkg::QUEUE_DEPTH];
	logic [mfr_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [mfr_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [mfr_pkg::QUEUE_CW-1:0]   count_q;
	logic                           do_push;
	logic                           do_pop;

	assign sts.full  = (count_q == mfr_pkg::QUEUE_CW'(mfr_pkg::QUEUE_DEPTH));
	assign sts.valid = (count_q != '0);
	assign do_push   = ctl.push && !sts.full;
	assign do_pop    = ctl.pop && sts.valid;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/mfr_back.sv */
module mfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  mfr_pkg::frame_t      frame,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output mfr_pkg::out_item_t   res_item
);

	logic                        res_valid_q;
	mfr_pkg::out_item_t          res_q;
	logic signed [15:0]          held_left_q;
	logic signed [15:0]          held_right_q;
	logic                        busy;
	logic signed [15:0]          next_left;
	logic signed [15:0]          next_right;

	assign busy = frame.led_word[mfr_pkg::BUSY_BIT];
	assign pop  = frame_valid && (!res_valid_q || !res_stall);

	always_comb begin
		next_left  = held_left_q;
		next_right = held_right_q;
		if (busy) begin
			next_left  = frame.cmd1;
			next_right = frame.cmd2;
		end else if (!frame.mission_active) begin
			next_left  = '0;
			next_right = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			held_left_q  <= '0;
			held_right_q <= '0;
		end else begin
			if (pop) begin
				res_valid_q  <= 1'b1;
				held_left_q  <= next_left;
				held_right_q <= next_right;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.word_cmd1         <= frame.cmd1;
			res_q.word_cmd2         <= frame.cmd2;
			res_q.speed_right       <= frame.speed_right;
			res_q.speed_left        <= frame.speed_left;
			res_q.battery_voltage   <= frame.battery_voltage;
			res_q.board_temperature <= frame.board_temperature;
			res_q.led_word          <= frame.led_word;
			res_q.busy_res          <= busy;
			res_q.distance_left     <= next_left;
			res_q.distance_right    <= next_right;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

/* rtl/motor_feedback_frame_receiver_unit.sv */
// Motor feedback frame receiver.
// Byte channel (byte_valid / byte_stall / byte_item): one UART byte per item
// plus the mission flag. Bytes are deframed into an 18-byte frame of nine
// little-endian words that opens with the start marker (low byte first); a
// marker pair seen anywhere restarts the frame.
// Result channel (res_valid / res_stall / res_item): one item per frame whose
// XOR of words 0..7 equals word 8; bad frames are dropped without a result.
// cfg_wr_en / cfg_wr_data write the 16-bit start marker (0xABCD after reset);
// write it only while the block is idle.
// Throughput: one byte per cycle while byte_stall is low. The deframer checks
// the frame in the cycle its last byte is accepted and writes it to the frame
// queue at that edge; the output register loads it from the queue once it is
// not holding a stalled item, and res_valid then rises.
// Stalls: the output register holds its item while res_stall is high; the
// two-entry frame queue absorbs further frames, and byte_stall rises only
// when that queue is full.
// Reset: clears the byte position, previous byte, held distances, queue and
// output valid, and restores the start marker.
module motor_feedback_frame_receiver_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  mfr_pkg::in_item_t    byte_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output mfr_pkg::out_item_t   res_item
);

	logic                  accept;
	logic                  push;
	logic                  pop;
	mfr_pkg::frame_t       frame_in;
	mfr_pkg::frame_t       frame_out;
	mfr_pkg::queue_ctl_t   q_ctl;
	mfr_pkg::queue_sts_t   q_sts;

	// Hold bytes back only while the queue has no room for a finished frame.
	assign byte_stall = q_sts.full;
	assign accept     = byte_valid && !byte_stall;

	assign q_ctl.push = push;
	assign q_ctl.pop  = pop;

	// Front: marker detect, byte position, frame store and checksum.
	mfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.item        (byte_item),
		.push        (push),
		.frame       (frame_in)
	);

	// Checked frames wait here so each side can stall on its own.
	mfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.wr_data (frame_in),
		.sts     (q_sts),
		.rd_data (frame_out)
	);

	// Back: distance hold update and output register.
	mfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (q_sts.valid),
		.frame       (frame_out),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item)
	);

endmodule
